// ===== design/spsi_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package spsi_pkg;

    localparam int CHANNELS          = 6;
    localparam int FRACTION_BITS_DEF = 16;
    localparam int POSE_W            = 15;
    localparam int TICK_W            = 13;
    localparam int STEP_W            = 6;
    localparam int QUEUE_DEPTH       = 2;
    localparam int QPTR_W            = 1;
    localparam int QCNT_W            = 2;

    localparam logic [POSE_W-1:0] POSE_RESET       = 15'd1500;
    localparam logic [STEP_W-1:0] STEP_COUNT_RESET = 6'd40;

    // ticks = floor(us * 128 / 625) = floor(us * TICK_MUL / 2^TICK_SHIFT), exact for 15-bit us
    localparam int                TICK_MUL_W = 23;
    localparam logic [TICK_MUL_W-1:0] TICK_MUL = 23'd6871948;
    localparam int                TICK_SHIFT = 25;

    typedef logic [CHANNELS-1:0][POSE_W-1:0] pose_arr_t;
    typedef logic [CHANNELS-1:0][TICK_W-1:0] tick_arr_t;

    typedef struct packed {
        logic [POSE_W-1:0] target_ch0;
        logic [POSE_W-1:0] target_ch1;
        logic [POSE_W-1:0] target_ch2;
        logic [POSE_W-1:0] target_ch3;
        logic [POSE_W-1:0] target_ch4;
        logic [POSE_W-1:0] target_ch5;
    } target_t;

    typedef struct packed {
        logic [TICK_W-1:0] ticks_ch0;
        logic [TICK_W-1:0] ticks_ch1;
        logic [TICK_W-1:0] ticks_ch2;
        logic [TICK_W-1:0] ticks_ch3;
        logic [TICK_W-1:0] ticks_ch4;
        logic [TICK_W-1:0] ticks_ch5;
        logic              last_of_move;
    } ticks_t;

    // head of the move queue as seen by the sequencer
    typedef struct packed {
        logic      valid;
        pose_arr_t target;
    } queue_head_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_SQ,
        ST_KW,
        ST_BLEND,
        ST_TICK,
        ST_EMIT,
        ST_FINAL
    } seq_state_t;

    function automatic pose_arr_t to_pose_arr(input target_t t);
        pose_arr_t a;
        a[0] = t.target_ch0;
        a[1] = t.target_ch1;
        a[2] = t.target_ch2;
        a[3] = t.target_ch3;
        a[4] = t.target_ch4;
        a[5] = t.target_ch5;
        return a;
    endfunction

    function automatic ticks_t pack_ticks(input tick_arr_t a, input logic last);
        ticks_t r;
        r.ticks_ch0    = a[0];
        r.ticks_ch1    = a[1];
        r.ticks_ch2    = a[2];
        r.ticks_ch3    = a[3];
        r.ticks_ch4    = a[4];
        r.ticks_ch5    = a[5];
        r.last_of_move = last;
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== design/spsi_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module spsi_front (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  cmd_valid,
    output logic                 cmd_stall,
    input  spsi_pkg::target_t    cmd_data,
    input  wire                  pop,
    output spsi_pkg::queue_head_t head
);
    import spsi_pkg::*;

    pose_arr_t         entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              push;

    assign cmd_stall = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign push      = cmd_valid && !cmd_stall;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= to_pose_arr(cmd_data);
        end
    end

    assign head.valid  = (count_reg != '0);
    assign head.target = entry_reg[rd_ptr_reg];

endmodule

`default_nettype wire

// ===== design/spsi_divider.sv =====
`timescale 1ns / 1ps
`default_nettype none

module spsi_divider #(
    parameter int FRACTION_BITS = spsi_pkg::FRACTION_BITS_DEF
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          start,
    input  wire [spsi_pkg::STEP_W-1:0]   step,
    input  wire [spsi_pkg::STEP_W-1:0]   divisor,
    output logic                         done,
    output logic [FRACTION_BITS:0]       quotient
);
    import spsi_pkg::*;

    localparam int DW    = FRACTION_BITS + STEP_W;
    localparam int CNT_W = $clog2(DW + 1);

    logic [DW-1:0]     quo_reg, quo_next;
    logic [STEP_W:0]   rem_reg, rem_next;
    logic [STEP_W-1:0] div_reg, div_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W:0]   shifted;
    logic              fits;

    // restoring division, one quotient bit per cycle
    assign shifted = {rem_reg[STEP_W-1:0], quo_reg[DW-1]};
    assign fits    = (shifted >= {1'b0, div_reg});

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next  = {step, FRACTION_BITS'(0)};
            rem_next  = '0;
            div_next  = divisor;
            cnt_next  = CNT_W'(DW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? (shifted - {1'b0, div_reg}) : shifted;
            quo_next = {quo_reg[DW-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg[FRACTION_BITS:0];

endmodule

`default_nettype wire

// ===== design/spsi_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module spsi_back #(
    parameter int FRACTION_BITS = spsi_pkg::FRACTION_BITS_DEF
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  spsi_pkg::queue_head_t        head,
    output logic                         pop,
    input  wire [spsi_pkg::STEP_W-1:0]   step_count,
    output logic                         res_valid,
    input  wire                          res_stall,
    output spsi_pkg::ticks_t             res_data
);
    import spsi_pkg::*;

    localparam int F    = FRACTION_BITS;
    localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam logic [CH_W-1:0] CH_LAST   = CH_W'(CHANNELS - 1);
    localparam logic [F+1:0]    THREE_ONE = (F+2)'(3) << F;

    seq_state_t        state_reg, state_next;
    logic [STEP_W-1:0] s_reg, s_next;
    logic [STEP_W-1:0] n_reg, n_next;
    logic [CH_W-1:0]   ch_reg, ch_next;
    logic              final_reg, final_next;
    pose_arr_t         current_reg, current_next;
    pose_arr_t         start_reg, start_next;
    tick_arr_t         ticks_reg, ticks_next;
    logic [F:0]        t_reg, t_next;
    logic [F:0]        sq_reg, sq_next;
    logic [F:0]        k_reg, k_next;
    logic              out_valid_reg, out_valid_next;
    ticks_t            out_data_reg, out_data_next;

    logic              div_start;
    logic              div_done;
    logic [F:0]        div_quotient;

    logic [2*F+1:0]    sq_prod;
    logic [F+1:0]      weight;
    logic [2*F+2:0]    k_prod;
    logic [POSE_W-1:0] from_us, to_us, diff, delta, pose_new;
    logic              rising;
    logic [F+POSE_W:0] blend_prod;
    logic [POSE_W+TICK_MUL_W-1:0] tick_prod;
    logic [TICK_W-1:0] tick_new;

    spsi_divider #(
        .FRACTION_BITS(FRACTION_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .step     (s_next),
        .divisor  (n_next),
        .done     (div_done),
        .quotient (div_quotient)
    );

    // smoothstep weight k = t^2 (3 - 2t)
    assign sq_prod = (2*F+2)'(t_reg) * (2*F+2)'(t_reg);
    assign weight  = THREE_ONE - {t_reg, 1'b0};
    assign k_prod  = (2*F+3)'(sq_reg) * (2*F+3)'(weight);

    // per-channel blend, magnitude floored and sign reapplied
    assign from_us    = start_reg[ch_reg];
    assign to_us      = head.target[ch_reg];
    assign rising     = (to_us >= from_us);
    assign diff       = rising ? (to_us - from_us) : (from_us - to_us);
    assign blend_prod = (F+POSE_W+1)'(diff) * (F+POSE_W+1)'(k_reg);
    assign delta      = blend_prod[F+POSE_W-1:F];
    assign pose_new   = rising ? (from_us + delta) : (from_us - delta);

    // microseconds to pwm ticks by reciprocal multiply
    assign tick_prod = (POSE_W+TICK_MUL_W)'(current_reg[ch_reg])
                     * (POSE_W+TICK_MUL_W)'(TICK_MUL);
    assign tick_new  = tick_prod[TICK_SHIFT+TICK_W-1:TICK_SHIFT];

    always_comb
    begin
        state_next     = state_reg;
        s_next         = s_reg;
        n_next         = n_reg;
        ch_next        = ch_reg;
        final_next     = final_reg;
        current_next   = current_reg;
        start_next     = start_reg;
        ticks_next     = ticks_reg;
        t_next         = t_reg;
        sq_next        = sq_reg;
        k_next         = k_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        div_start      = 1'b0;
        pop            = 1'b0;

        if (out_valid_reg && !res_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (head.valid)
                begin
                    start_next = current_reg;
                    n_next     = step_count;
                    if (step_count == '0)
                    begin
                        state_next = ST_FINAL;
                    end
                    else
                    begin
                        s_next     = STEP_W'(1);
                        div_start  = 1'b1;
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    t_next     = div_quotient;
                    state_next = ST_SQ;
                end
            end
            ST_SQ:
            begin
                sq_next    = sq_prod[2*F:F];
                state_next = ST_KW;
            end
            ST_KW:
            begin
                k_next     = k_prod[2*F:F];
                ch_next    = '0;
                final_next = 1'b0;
                state_next = ST_BLEND;
            end
            ST_BLEND:
            begin
                current_next[ch_reg] = pose_new;
                state_next           = ST_TICK;
            end
            ST_TICK:
            begin
                ticks_next[ch_reg] = tick_new;
                if (ch_reg == CH_LAST)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    ch_next    = ch_reg + 1'b1;
                    state_next = final_reg ? ST_TICK : ST_BLEND;
                end
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || !res_stall)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = pack_ticks(ticks_reg, final_reg);
                    if (final_reg)
                    begin
                        pop        = 1'b1;
                        s_next     = '0;
                        state_next = ST_IDLE;
                    end
                    else if (s_reg == n_reg)
                    begin
                        state_next = ST_FINAL;
                    end
                    else
                    begin
                        s_next     = s_reg + 1'b1;
                        div_start  = 1'b1;
                        state_next = ST_DIV;
                    end
                end
            end
            ST_FINAL:
            begin
                current_next = head.target;
                ch_next      = '0;
                final_next   = 1'b1;
                state_next   = ST_TICK;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            s_reg         <= '0;
            n_reg         <= '0;
            ch_reg        <= '0;
            final_reg     <= 1'b0;
            current_reg   <= {CHANNELS{POSE_RESET}};
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            s_reg         <= s_next;
            n_reg         <= n_next;
            ch_reg        <= ch_next;
            final_reg     <= final_next;
            current_reg   <= current_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        start_reg    <= start_next;
        ticks_reg    <= ticks_next;
        t_reg        <= t_next;
        sq_reg       <= sq_next;
        k_reg        <= k_next;
        out_data_reg <= out_data_next;
    end

    assign res_valid = out_valid_reg;
    assign res_data  = out_data_reg;

endmodule

`default_nettype wire

// ===== design/servo_pose_smoothstep_interpolator_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// servo pose smoothstep interpolator: each command transfer carries a target pulse width in
// microseconds for six servo channels. the block takes its current pose as the start, walks to
// the target along k = t^2 (3 - 2t) in step_count steps (t = s / step_count), and after every
// step sends one result transfer with the pwm tick count of each channel (4096 ticks per
// 20 ms). one more result with the exact target and last_of_move set closes the move; with a
// step count of zero only that closing result is sent. the pose starts at 1500 us after reset.
// a two-entry command queue sits in front of the sequencer; the move being played out stays at
// the queue head until its closing result goes out, so one more move can wait behind it. a
// finished result waits in the output register while the next step is worked out. in each
// step the serial divider for t takes one quotient bit per cycle and hands t over, then t^2
// and k are registered in turn, then a blend and a tick conversion run per channel on one
// shared multiplier each, and last the output register is loaded, which waits while the
// output side stalls. the user must write step_count through cfg_we / cfg_data only while
// idle; the block itself does not enforce this.

module servo_pose_smoothstep_interpolator_core #(
    parameter int FRACTION_BITS = spsi_pkg::FRACTION_BITS_DEF
) (
    input  wire                         clk,
    input  wire                         rst_n,
    input  wire                         cmd_valid,
    output logic                        cmd_stall,
    input  spsi_pkg::target_t           cmd_data,
    output logic                        res_valid,
    input  wire                         res_stall,
    output spsi_pkg::ticks_t            res_data,
    input  wire                         cfg_we,
    input  wire [spsi_pkg::STEP_W-1:0]  cfg_data
);
    import spsi_pkg::*;

    // step count register, read by the sequencer at the start of each move
    logic [STEP_W-1:0] step_count_reg, step_count_next;

    // queue head and pop between the front and the sequencer
    queue_head_t       head;
    logic              pop;

    always_comb
    begin
        step_count_next = cfg_we ? cfg_data : step_count_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_count_reg <= STEP_COUNT_RESET;
        end
        else
        begin
            step_count_reg <= step_count_next;
        end
    end

    // front: takes command transfers into the move queue
    spsi_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd_data  (cmd_data),
        .pop       (pop),
        .head      (head)
    );

    // back: plays out one move at a time and drives the result transfers
    spsi_back #(
        .FRACTION_BITS(FRACTION_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .pop        (pop),
        .step_count (step_count_reg),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .res_data   (res_data)
    );

endmodule

`default_nettype wire
